@@ hw/rtl/sdto_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sdto_pkg;

  // Field widths
  localparam int COORD_W   = 8;
  localparam int PIX_W     = 16;
  localparam int SCALE_W   = 4;
  localparam int CODE_W    = 4;
  localparam int CODES_W   = 64;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 3;

  // Reciprocal of the scale in 12 fractional bits, rounded down from 4095 / s.
  localparam int RECIP_W = 12;
  localparam int PROD_W  = COORD_W + RECIP_W;

  // Character cell geometry in glyph units, and the divide-by-five constants.
  localparam int CELL_UNITS_W = 5;
  localparam int CELL_UNITS_H = 9;
  localparam int DIV5_MUL     = 205;
  localparam int DIV5_SHIFT   = 10;
  localparam int CI_W         = 6;
  localparam int MAX_CHARS    = 16;
  localparam int CHAR_SEL_W   = 4;

  // Glyph codes
  localparam logic [CODE_W-1:0] DASH_CODE = 4'd10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_SCALE       = 3'd2,
    REG_BACK_VALUE  = 3'd3,
    REG_FRONT_VALUE = 3'd4,
    REG_CHAR_CODES  = 3'd5,
    REG_CHAR_COUNT  = 3'd6
  } reg_idx_t;

  // Glyph ROM: 11 glyphs of 7 rows, bit 2 is the left column.
  localparam logic [2:0] GLYPH_ROM [0:10][0:6] = '{
    '{3'd7, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd7},
    '{3'd1, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd7, 3'd1, 3'd1, 3'd7, 3'd4, 3'd4, 3'd7},
    '{3'd7, 3'd1, 3'd1, 3'd7, 3'd1, 3'd1, 3'd7},
    '{3'd5, 3'd5, 3'd5, 3'd7, 3'd1, 3'd1, 3'd1},
    '{3'd7, 3'd4, 3'd4, 3'd7, 3'd1, 3'd1, 3'd7},
    '{3'd7, 3'd4, 3'd4, 3'd7, 3'd5, 3'd5, 3'd7},
    '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd7, 3'd5, 3'd5, 3'd7, 3'd5, 3'd5, 3'd7},
    '{3'd7, 3'd5, 3'd5, 3'd7, 3'd1, 3'd1, 3'd7},
    '{3'd0, 3'd0, 3'd0, 3'd7, 3'd0, 3'd0, 3'd0}
  };

  // Pixel item as it enters the pipeline.
  typedef struct packed {
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    logic signed [PIX_W-1:0] pix;
  } sdto_pix_t;

  // Pixel position in glyph units, handed from the divider to the drawing stages.
  typedef struct packed {
    logic                    ge_x;
    logic                    ge_y;
    logic [COORD_W-1:0]      qx;
    logic [COORD_W-1:0]      qy;
    logic signed [PIX_W-1:0] pix;
  } sdto_quot_t;

  // A scale of zero behaves as a scale of one.
  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
    eff_scale = (s == '0) ? SCALE_W'(1) : s;
  endfunction

  // Reciprocal table, floor(4095 / s).
  function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] s);
    case (s)
      4'd2:    recip = 12'd2047;
      4'd3:    recip = 12'd1365;
      4'd4:    recip = 12'd1023;
      4'd5:    recip = 12'd819;
      4'd6:    recip = 12'd682;
      4'd7:    recip = 12'd585;
      4'd8:    recip = 12'd511;
      4'd9:    recip = 12'd455;
      4'd10:   recip = 12'd409;
      4'd11:   recip = 12'd372;
      4'd12:   recip = 12'd341;
      4'd13:   recip = 12'd315;
      4'd14:   recip = 12'd292;
      4'd15:   recip = 12'd273;
      default: recip = 12'd4095;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scaled_digit_text_overlay.sv @@
// Channel  Dir  tdata fields (low bit up)                  tuser
// in_      in   pixel_x[7:0], pixel_y[15:8], pixel_in[31:16]  -
// out_     out  pixel_out[15:0]                              in_cell
// cfg_     in   write enable, register index, 64-bit data     -
//
// One item per clock when the output is taken; each item passes five register
// stages in order: offset, reciprocal multiply, quotient correction, cell
// decode, glyph lookup into the output register.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register defaults.
// A stall at the output fills empty stages first, then holds every stage in place.
`timescale 1ns / 1ps
`default_nettype none

module scaled_digit_text_overlay import sdto_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [31:0]          in_tdata,   // pixel_x, pixel_y, pixel_in
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [15:0]               out_tdata,  // pixel_out
  output logic                      out_tuser,  // in_cell
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CODES_W-1:0]   cfg_wdata
);

  logic [COORD_W-1:0]      origin_x_r;
  logic [COORD_W-1:0]      origin_y_r;
  logic [SCALE_W-1:0]      scale_r;
  logic signed [PIX_W-1:0] back_value_r;
  logic signed [PIX_W-1:0] front_value_r;
  logic [CODES_W-1:0]      char_codes_r;
  logic [COUNT_W-1:0]      char_count_r;

  sdto_pix_t               in_pix;
  sdto_quot_t              quot;
  logic                    quot_valid, quot_ready;
  logic signed [PIX_W-1:0] pix_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      scale_r       <= SCALE_W'(1);
      back_value_r  <= '0;
      front_value_r <= PIX_W'(255);
      char_codes_r  <= '0;
      char_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:    origin_x_r    <= cfg_wdata[COORD_W-1:0];
        REG_ORIGIN_Y:    origin_y_r    <= cfg_wdata[COORD_W-1:0];
        REG_SCALE:       scale_r       <= cfg_wdata[SCALE_W-1:0];
        REG_BACK_VALUE:  back_value_r  <= cfg_wdata[PIX_W-1:0];
        REG_FRONT_VALUE: front_value_r <= cfg_wdata[PIX_W-1:0];
        REG_CHAR_CODES:  char_codes_r  <= cfg_wdata;
        REG_CHAR_COUNT:  char_count_r  <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the input item.
  assign in_pix.px  = in_tdata[7:0];
  assign in_pix.py  = in_tdata[15:8];
  assign in_pix.pix = in_tdata[31:16];

  sdto_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .origin_x  (origin_x_r),
    .origin_y  (origin_y_r),
    .scale     (scale_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_pix),
    .out_valid (quot_valid),
    .out_ready (quot_ready),
    .out_data  (quot)
  );

  sdto_draw u_draw (
    .clk         (clk),
    .rst_n       (rst_n),
    .back_value  (back_value_r),
    .front_value (front_value_r),
    .char_codes  (char_codes_r),
    .char_count  (char_count_r),
    .in_valid    (quot_valid),
    .in_ready    (quot_ready),
    .in_data     (quot),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_pix     (pix_out),
    .out_cell    (out_tuser)
  );

  assign out_tdata = pix_out;

endmodule

`default_nettype wire

@@ hw/rtl/sdto_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdto_div import sdto_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [COORD_W-1:0] origin_x,
  input  wire logic [COORD_W-1:0] origin_y,
  input  wire logic [SCALE_W-1:0] scale,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sdto_pix_t          in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sdto_quot_t              out_data
);

  logic [SCALE_W-1:0] s_eff;
  logic [RECIP_W-1:0] m_recip;

  // Stage 1: offset from the origin.
  logic                    s1_v_r, s1_v_nxt, s1_ld;
  logic                    s1_gex_r, s1_gey_r;
  logic [COORD_W-1:0]      s1_dx_r, s1_dy_r;
  logic signed [PIX_W-1:0] s1_pix_r;

  // Stage 2: multiply by the reciprocal of the scale.
  logic                    s2_v_r, s2_v_nxt, s2_ld;
  logic                    s2_gex_r, s2_gey_r;
  logic [COORD_W-1:0]      s2_dx_r, s2_dy_r;
  logic [COORD_W-1:0]      s2_qex_r, s2_qey_r;
  logic signed [PIX_W-1:0] s2_pix_r;
  logic [PROD_W-1:0]       prod_x, prod_y;

  // Stage 3: one-step correction of the quotient.
  logic                    s3_v_r, s3_v_nxt, s3_ld;
  sdto_quot_t              s3_q_r, s3_q_nxt;
  logic [RECIP_W-1:0]      back_x, back_y, rem_x, rem_y;

  assign s_eff   = eff_scale(scale);
  assign m_recip = recip(s_eff);

  // A stage loads when it is empty or its content moves on.
  assign s3_ld    = !s3_v_r || out_ready;
  assign s2_ld    = !s2_v_r || s3_ld;
  assign s1_ld    = !s1_v_r || s2_ld;
  assign in_ready = s1_ld;

  assign s1_v_nxt = s1_ld ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_ld ? s1_v_r : s2_v_r;
  assign s3_v_nxt = s3_ld ? s2_v_r : s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  // Stage 1 datapath.
  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_gex_r <= in_data.px >= origin_x;
      s1_gey_r <= in_data.py >= origin_y;
      s1_dx_r  <= in_data.px - origin_x;
      s1_dy_r  <= in_data.py - origin_y;
      s1_pix_r <= in_data.pix;
    end
  end

  // Stage 2 datapath: the estimate is the true quotient or one less.
  assign prod_x = PROD_W'(s1_dx_r) * PROD_W'(m_recip);
  assign prod_y = PROD_W'(s1_dy_r) * PROD_W'(m_recip);

  always_ff @(posedge clk) begin
    if (s2_ld) begin
      s2_gex_r <= s1_gex_r;
      s2_gey_r <= s1_gey_r;
      s2_dx_r  <= s1_dx_r;
      s2_dy_r  <= s1_dy_r;
      s2_qex_r <= prod_x[PROD_W-1:RECIP_W];
      s2_qey_r <= prod_y[PROD_W-1:RECIP_W];
      s2_pix_r <= s1_pix_r;
    end
  end

  // Stage 3 datapath: bump the estimate when the remainder reaches the scale.
  assign back_x = RECIP_W'(s2_qex_r) * RECIP_W'(s_eff);
  assign back_y = RECIP_W'(s2_qey_r) * RECIP_W'(s_eff);
  assign rem_x  = RECIP_W'(s2_dx_r) - back_x;
  assign rem_y  = RECIP_W'(s2_dy_r) - back_y;

  always_comb begin
    s3_q_nxt.ge_x = s2_gex_r;
    s3_q_nxt.ge_y = s2_gey_r;
    s3_q_nxt.qx   = (rem_x >= RECIP_W'(s_eff)) ? s2_qex_r + 1'b1 : s2_qex_r;
    s3_q_nxt.qy   = (rem_y >= RECIP_W'(s_eff)) ? s2_qey_r + 1'b1 : s2_qey_r;
    s3_q_nxt.pix  = s2_pix_r;
  end

  always_ff @(posedge clk) begin
    if (s3_ld) begin
      s3_q_r <= s3_q_nxt;
    end
  end

  assign out_valid = s3_v_r;
  assign out_data  = s3_q_r;

  // The estimate never overshoots the true quotient.
  a_est_under: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (back_x <= RECIP_W'(s2_dx_r)) && (back_y <= RECIP_W'(s2_dy_r)))
    else $error("quotient estimate above true quotient");

  // The estimate is at most one below the true quotient.
  a_est_close: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (rem_x < RECIP_W'({s_eff, 1'b0})) && (rem_y < RECIP_W'({s_eff, 1'b0})))
    else $error("quotient estimate more than one low");

  // A held item stays in the last stage until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !out_ready |=> s3_v_r)
    else $error("divider dropped a stalled item");

endmodule

`default_nettype wire

@@ hw/rtl/sdto_draw.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdto_draw import sdto_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic signed [PIX_W-1:0] back_value,
  input  wire logic signed [PIX_W-1:0] front_value,
  input  wire logic [CODES_W-1:0]      char_codes,
  input  wire logic [COUNT_W-1:0]      char_count,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire sdto_quot_t              in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [PIX_W-1:0]      out_pix,
  output logic                         out_cell
);

  localparam int DIV5_PROD_W = 2 * COORD_W;

  // Stage 4: character index, unit column and code.
  logic                     s4_v_r, s4_v_nxt, s4_ld;
  logic                     s4_hit_r;
  logic [2:0]               s4_ux_r;
  logic [3:0]               s4_uy_r;
  logic [CODE_W-1:0]        s4_code_r;
  logic signed [PIX_W-1:0]  s4_pix_r;
  logic [DIV5_PROD_W-1:0]   div5_prod;
  logic [CI_W-1:0]          ci;
  logic [COORD_W-1:0]       ux_full;
  logic [COUNT_W-1:0]       n_chars;
  logic [CODE_W-1:0]        raw_code;
  logic                     hit;

  // Stage 5: glyph lookup and output register.
  logic                     s5_v_r, s5_v_nxt, s5_ld;
  logic signed [PIX_W-1:0]  s5_pix_r, s5_pix_nxt;
  logic                     s5_cell_r;
  logic [2:0]               glyph_row;
  logic [1:0]               bit_sel;
  logic                     interior, glyph_on;

  assign s5_ld    = !s5_v_r || out_ready;
  assign s4_ld    = !s4_v_r || s5_ld;
  assign in_ready = s4_ld;

  assign s4_v_nxt = s4_ld ? in_valid : s4_v_r;
  assign s5_v_nxt = s5_ld ? s4_v_r : s5_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s4_v_r <= s4_v_nxt;
      s5_v_r <= s5_v_nxt;
    end
  end

  // Unit column splits into character index and column within the cell.
  assign div5_prod = DIV5_PROD_W'(in_data.qx) * DIV5_PROD_W'(DIV5_MUL);
  assign ci        = div5_prod[DIV5_SHIFT +: CI_W];
  assign ux_full   = in_data.qx - (COORD_W'(ci) * COORD_W'(CELL_UNITS_W));
  assign n_chars   = (char_count > COUNT_W'(MAX_CHARS)) ? COUNT_W'(MAX_CHARS) : char_count;
  assign raw_code  = char_codes[ci[CHAR_SEL_W-1:0] * CODE_W +: CODE_W];
  assign hit       = in_data.ge_x && in_data.ge_y
                  && (in_data.qy < COORD_W'(CELL_UNITS_H))
                  && (CI_W'(n_chars) > ci);

  always_ff @(posedge clk) begin
    if (s4_ld) begin
      s4_hit_r  <= hit;
      s4_ux_r   <= ux_full[2:0];
      s4_uy_r   <= in_data.qy[3:0];
      s4_code_r <= (raw_code > DASH_CODE) ? DASH_CODE : raw_code;
      s4_pix_r  <= in_data.pix;
    end
  end

  // Border units never light; inside, the glyph bit picks the value.
  assign interior  = (s4_ux_r != 3'd0) && (s4_ux_r != 3'd4)
                  && (s4_uy_r != 4'd0) && (s4_uy_r != 4'd8);
  assign glyph_row = GLYPH_ROM[s4_code_r][3'(s4_uy_r - 4'd1)];
  assign bit_sel   = 2'(3'd3 - s4_ux_r);
  assign glyph_on  = interior && glyph_row[bit_sel];

  always_comb begin
    if (!s4_hit_r) begin
      s5_pix_nxt = s4_pix_r;
    end else if (glyph_on) begin
      s5_pix_nxt = front_value;
    end else begin
      s5_pix_nxt = back_value;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ld) begin
      s5_pix_r  <= s5_pix_nxt;
      s5_cell_r <= s4_hit_r;
    end
  end

  assign out_valid = s5_v_r;
  assign out_pix   = s5_pix_r;
  assign out_cell  = s5_cell_r;

  // A pixel inside a cell carries one of the two drawing values.
  a_cell_value: assert property (@(posedge clk) disable iff (!rst_n)
    s5_v_r && s5_cell_r |-> (s5_pix_r == front_value) || (s5_pix_r == back_value))
    else $error("cell pixel has neither drawing value");

  // The column within a cell stays below the cell width.
  a_ux_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && s4_hit_r |-> s4_ux_r < 3'(CELL_UNITS_W))
    else $error("unit column outside the cell");

  // A result waiting at the output is not replaced.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s5_v_r && !out_ready |=> s5_v_r && $stable(s5_pix_r) && $stable(s5_cell_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire

@@ tb/scaled_digit_text_overlay_tb.sv @@
`timescale 1ns / 1ps

module scaled_digit_text_overlay_tb;
  import sdto_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int PIPE_DEPTH      = 5;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 60;
  localparam int REPORT_MAX      = 10;

  // No register lives at this index; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic             in_cell;
    logic [PIX_W-1:0] pixel;
  } overlay_result_t;

  // Shadow of the overlay registers plus the queue of overlaid pixels still owed.
  class overlay_scoreboard;
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    logic [SCALE_W-1:0] scale;
    logic [PIX_W-1:0]   back_val;
    logic [PIX_W-1:0]   front_val;
    logic [CODES_W-1:0] codes;
    logic [COUNT_W-1:0] count;
    overlay_result_t    owed_q[$];
    int                 mismatches;

    function new();
      org_x      = '0;
      org_y      = '0;
      scale      = 4'd1;
      back_val   = '0;
      front_val  = 16'd255;
      codes      = '0;
      count      = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CODES_W-1:0] val);
      case (idx)
        REG_ORIGIN_X:    org_x = val[COORD_W-1:0];
        REG_ORIGIN_Y:    org_y = val[COORD_W-1:0];
        REG_SCALE:       scale = val[SCALE_W-1:0];
        REG_BACK_VALUE:  back_val = val[PIX_W-1:0];
        REG_FRONT_VALUE: front_val = val[PIX_W-1:0];
        REG_CHAR_CODES:  codes = val;
        REG_CHAR_COUNT:  count = val[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Seven 3-bit rows per glyph, top row in the high octal digit, left column in bit 2.
    function logic [20:0] glyph_rows(logic [CODE_W-1:0] code);
      case (code)
        4'd0:    glyph_rows = 21'o7555557;
        4'd1:    glyph_rows = 21'o1311111;
        4'd2:    glyph_rows = 21'o7117447;
        4'd3:    glyph_rows = 21'o7117117;
        4'd4:    glyph_rows = 21'o5557111;
        4'd5:    glyph_rows = 21'o7447117;
        4'd6:    glyph_rows = 21'o7447557;
        4'd7:    glyph_rows = 21'o7111111;
        4'd8:    glyph_rows = 21'o7557557;
        4'd9:    glyph_rows = 21'o7557117;
        default: glyph_rows = 21'o0007000;
      endcase
    endfunction

    function overlay_result_t overlay_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                            logic [PIX_W-1:0] pin);
      int s, cell_w, cell_h, n, dx, dy, ci, ux, uy;
      logic [CODE_W-1:0] code;
      logic [20:0] rows;
      overlay_result_t res;
      res.in_cell = 1'b0;
      res.pixel   = pin;
      s      = (scale == '0) ? 1 : int'(scale);
      cell_w = 5 * s;
      cell_h = 9 * s;
      n      = (count > MAX_CHARS) ? MAX_CHARS : int'(count);
      if (x < org_x || y < org_y) return res;
      dx = int'(x) - int'(org_x);
      dy = int'(y) - int'(org_y);
      if (dy >= cell_h) return res;
      ci = dx / cell_w;
      if (ci >= n) return res;
      ux   = (dx % cell_w) / s;
      uy   = dy / s;
      code = codes[ci*CODE_W +: CODE_W];
      if (code > DASH_CODE) code = DASH_CODE;
      res.in_cell = 1'b1;
      // The one-unit border around the glyph is always background.
      if (ux == 0 || ux == 4 || uy == 0 || uy == 8) begin
        res.pixel = back_val;
      end else begin
        rows      = glyph_rows(code);
        res.pixel = rows[(7 - uy) * 3 + (3 - ux)] ? front_val : back_val;
      end
      return res;
    endfunction

    function void note_pixel(logic [31:0] word);
      owed_q.push_back(overlay_pixel(word[7:0], word[15:8], word[31:16]));
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic in_cell);
      overlay_result_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result %h/%b with no pixel pending", $time, pix, in_cell);
        return;
      end
      want = owed_q.pop_front();
      if (want.pixel !== pix || want.in_cell !== in_cell) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: pixel_out exp %h got %h, in_cell exp %b got %b",
                   $time, want.pixel, pix, want.in_cell, in_cell);
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;   // pixel_x, pixel_y, pixel_in
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;         // pixel_out
  logic                 out_tuser;         // in_cell
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CODES_W-1:0]   cfg_wdata  = '0;

  overlay_scoreboard sb;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_asked   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int cycle_count  = 0;

  scaled_digit_text_overlay u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("scaled_digit_text_overlay regression: fail");
      $finish;
    end
  end

  // Record accepted pixels and check accepted results at the same edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen  <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input logic [15:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODES_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Fill the bits above a register's width with noise; the block must drop them.
  function automatic logic [CODES_W-1:0] with_noise(input logic [CODES_W-1:0] v, input int w);
    logic [CODES_W-1:0] r;
    r = {$urandom, $urandom};
    for (int i = 0; i < w; i++) r[i] = v[i];
    return r;
  endfunction

  task automatic load_setting(input logic [7:0] ox, input logic [7:0] oy,
                              input logic [3:0] sc, input logic [15:0] bk,
                              input logic [15:0] ft, input logic [63:0] cd,
                              input logic [4:0] cnt);
    put_reg(REG_UNUSED, {$urandom, $urandom});
    put_reg(REG_ORIGIN_X, with_noise(CODES_W'(ox), COORD_W));
    put_reg(REG_ORIGIN_Y, with_noise(CODES_W'(oy), COORD_W));
    put_reg(REG_SCALE, with_noise(CODES_W'(sc), SCALE_W));
    put_reg(REG_BACK_VALUE, with_noise(CODES_W'(bk), PIX_W));
    put_reg(REG_FRONT_VALUE, with_noise(CODES_W'(ft), PIX_W));
    put_reg(REG_CHAR_CODES, cd);
    put_reg(REG_CHAR_COUNT, with_noise(CODES_W'(cnt), COUNT_W));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0]  ox, oy;
    logic [3:0]  sc;
    logic [4:0]  cnt;
    int          span_x, span_y, xi, yi;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers draw no characters, so everything passes through.
    send_pixel(8'd0, 8'd0, 16'h0000);
    send_pixel(8'd255, 8'd255, 16'h8000);
    send_pixel(8'd0, 8'd255, 16'h7FFF);
    wait_drained();

    // Scale zero, all sixteen codes, count above the character limit.
    load_setting(8'd10, 8'd20, 4'd0, 16'h8000, 16'h7FFF, 64'hFEDC_BA98_7654_3210, 5'd31);
    send_pixel(8'd10, 8'd20, 16'h1234);   // cell corner, border
    send_pixel(8'd11, 8'd21, 16'h1234);   // top left of glyph zero, lit
    send_pixel(8'd12, 8'd22, 16'h1234);   // hollow middle of zero
    send_pixel(8'd9, 8'd20, 16'hFFFF);    // left of origin
    send_pixel(8'd10, 8'd19, 16'h0000);   // above origin
    send_pixel(8'd10, 8'd29, 16'h8000);   // just below the cells
    send_pixel(8'd10, 8'd28, 16'h1234);   // bottom border
    send_pixel(8'd14, 8'd24, 16'h1234);   // right border
    send_pixel(8'd86, 8'd24, 16'h1234);   // last character, code above dash draws a dash
    send_pixel(8'd90, 8'd24, 16'h7FFF);   // just past the clipped character count
    send_pixel(8'd255, 8'd255, 16'h5A5A);
    send_pixel(8'd0, 8'd0, 16'hA5A5);
    wait_drained();

    // Largest scale, one character.
    load_setting(8'd0, 8'd0, 4'd15, 16'h0001, 16'hFFFE, 64'h0000_0000_0000_0008, 5'd1);
    send_pixel(8'd0, 8'd0, 16'h1111);
    send_pixel(8'd15, 8'd15, 16'h1111);
    send_pixel(8'd74, 8'd134, 16'h1111);
    send_pixel(8'd75, 8'd0, 16'h2222);
    send_pixel(8'd0, 8'd135, 16'h3333);
    send_pixel(8'd30, 8'd60, 16'h4444);
    send_pixel(8'd30, 8'd30, 16'h5555);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin ox = 8'd0; oy = 8'd0; sc = 4'd1; cnt = 5'd16; end
        1: begin ox = 8'd255; oy = 8'd255; sc = 4'd15; cnt = 5'd16; end
        2: begin ox = 8'($urandom); oy = 8'($urandom); sc = 4'd0; cnt = 5'd31; end
        3: begin ox = 8'd0; oy = 8'd0; sc = 4'd15; cnt = 5'd3; end
        default: begin
          ox  = 8'($urandom_range(200));
          oy  = 8'($urandom_range(200));
          sc  = 4'($urandom_range(15));
          cnt = 5'($urandom_range(31));
        end
      endcase
      load_setting(ox, oy, sc, 16'($urandom), 16'($urandom), {$urandom, $urandom}, cnt);

      // Idling pattern rotates through none, sender, receiver and both.
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
      endcase

      span_x = 5 * ((sc == 0) ? 1 : int'(sc)) * ((cnt > MAX_CHARS) ? MAX_CHARS : int'(cnt));
      span_y = 9 * ((sc == 0) ? 1 : int'(sc));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Mid-phase pressure: a long output hold-off, or a full drain of the pipeline.
        if (k == ITEMS_PER_PHASE / 2) begin
          if (ph == 0) hold_asked = hold_asked + 1;
          if (ph == 5) wait_drained();
        end
        // Most pixels land on or around the text, the rest anywhere.
        if ($urandom_range(3) != 0) begin
          xi = int'(ox) - 3 + int'($urandom_range(span_x + 6));
          yi = int'(oy) - 2 + int'($urandom_range(span_y + 4));
          xi = (xi < 0) ? 0 : ((xi > 255) ? 255 : xi);
          yi = (yi < 0) ? 0 : ((yi > 255) ? 255 : yi);
        end else begin
          xi = int'($urandom_range(255));
          yi = int'($urandom_range(255));
        end
        send_pixel(8'(xi), 8'(yi), 16'($urandom));
      end
      wait_drained();
    end

    rx_stall_pct = 0;
    wait_drained();
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("scaled_digit_text_overlay regression: pass");
    end else begin
      $display("scaled_digit_text_overlay regression: fail");
    end
    $finish;
  end

endmodule
